[sv/stm_pkg.sv]
// ----------------------------------------------------------------------------
// stm_pkg
// Shared constants, controller states and the command/status bundles of the
// sliding trimmed mean core.
// ----------------------------------------------------------------------------
package stm_pkg;

    localparam int MAX_WINDOW  = 128;
    localparam int SAMPLE_BITS = 16;

    localparam int IDX_W   = $clog2(MAX_WINDOW);
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_BITS + IDX_W;
    localparam int DCNT_W  = $clog2(SUM_W);
    localparam int WS_W    = 8;
    localparam int TC_W    = 6;
    localparam int CIDX_W  = 8;

    localparam logic [CIDX_W-1:0] REG_WINDOW_SIZE = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_TRIM_COUNT  = CIDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_REMOVE,
        ST_INSERT,
        ST_CHECK,
        ST_SUM,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic remove;
        logic insert;
        logic sum_init;
        logic sum_step;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic zero_win;
        logic full;
        logic mean_ok;
        logic sum_last;
        logic div_last;
    } status_t;

endpackage

[sv/sliding_trimmed_mean_core.sv]
// ----------------------------------------------------------------------------
// sliding_trimmed_mean_core
// Sliding-window trimmed mean over unsigned samples.
// ----------------------------------------------------------------------------
// One result beat per sample beat. The core handles one sample at a time:
// accept, ring read, sorted removal, sorted insertion and a check, each in
// its own state. Once the window is full and the trim is valid, the middle
// sum is accumulated one sorted cell per cycle, one cell per kept sample
// (the window length, capped at 128, less 2*trim_count). A restoring
// divider then produces the quotient, and the output register is loaded
// once it is free. Without a valid mean the sum and the divide are skipped;
// with window_size 0 the core goes from accept straight to the output. The
// result register lets the next sample be taken while a result waits.
// Register writes restart the window; the user must make them while the
// core is idle, as the core itself does not enforce this.
module sliding_trimmed_mean_core
    import stm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_ready_res,
    output logic                   m_config_error,
    output logic [SAMPLE_BITS-1:0] m_average,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CIDX_W-1:0]      cfg_index,
    input  logic [WS_W-1:0]        cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    stm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    stm_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_sample       (s_sample),
        .m_ready_res    (m_ready_res),
        .m_config_error (m_config_error),
        .m_average      (m_average)
    );

endmodule

[sv/stm_ram.sv]
// ----------------------------------------------------------------------------
// stm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/stm_sorter.sv]
// ----------------------------------------------------------------------------
// stm_sorter
// Row of sorted sample cells. Each cell decides locally whether it keeps its
// value, takes a neighbor's or takes the new sample, so a removal or an
// insertion updates every cell together on the next clock edge.
// ----------------------------------------------------------------------------
module stm_sorter
    import stm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   remove,
    input  logic                   insert,
    input  logic [CNT_W-1:0]       n,
    input  logic [SAMPLE_BITS-1:0] v,
    input  logic [IDX_W-1:0]       rd_idx,
    output logic [SAMPLE_BITS-1:0] rd_data
);

    logic [SAMPLE_BITS-1:0] cell_reg  [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] cell_next [MAX_WINDOW];
    logic                   gt [MAX_WINDOW];

    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            gt[i] = (CNT_W'(i) < n) && (cell_reg[i] > v);
        end
        for (int i = 0; i < MAX_WINDOW; i++) begin
            cell_next[i] = cell_reg[i];
            if (remove) begin
                // sorted, so the first cell not below v holds the copy to drop
                if ((CNT_W'(i + 1) < n) && (cell_reg[i] >= v)) begin
                    cell_next[i] = (i + 1 < MAX_WINDOW) ? cell_reg[(i + 1) % MAX_WINDOW]
                                                        : cell_reg[i];
                end
            end else if (insert && (CNT_W'(i) <= n)) begin
                if ((i > 0) && gt[(i + MAX_WINDOW - 1) % MAX_WINDOW]) begin
                    cell_next[i] = cell_reg[(i + MAX_WINDOW - 1) % MAX_WINDOW];
                end else if (gt[i] || (CNT_W'(i) == n)) begin
                    cell_next[i] = v;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            cell_reg[i] <= cell_next[i];
        end
    end

    assign rd_data = cell_reg[rd_idx];

endmodule

[sv/stm_datapath.sv]
// ----------------------------------------------------------------------------
// stm_datapath
// Configuration registers, sample ring, sorted cells, middle-sum accumulator,
// restoring divider and result registers.
// ----------------------------------------------------------------------------
module stm_datapath
    import stm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic                   cfg_we,
    input  logic [CIDX_W-1:0]      cfg_index,
    input  logic [WS_W-1:0]        cfg_data,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    output logic                   m_ready_res,
    output logic                   m_config_error,
    output logic [SAMPLE_BITS-1:0] m_average
);

    logic [WS_W-1:0]        ws_reg;
    logic [TC_W-1:0]        tc_reg;
    logic [IDX_W-1:0]       wp_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SUM_W-1:0]       acc_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       rem_reg;
    logic [SUM_W-1:0]       quot_reg;
    logic [DCNT_W-1:0]      dcnt_reg;
    logic                   out_ready_reg;
    logic                   out_err_reg;
    logic [SAMPLE_BITS-1:0] out_avg_reg;

    logic [CNT_W-1:0]       w;
    logic                   err;
    logic [CNT_W-1:0]       divisor;
    logic [CNT_W-1:0]       hi_idx;
    logic [CNT_W-1:0]       wp_inc;
    logic [CNT_W-1:0]       ins_n;
    logic [SAMPLE_BITS-1:0] ring_rdata;
    logic [SAMPLE_BITS-1:0] cell_rdata;
    logic [SUM_W-1:0]       acc_sum;
    logic [CNT_W:0]         trial;
    logic                   trial_ge;
    logic                   restart;

    assign w       = (ws_reg > WS_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : CNT_W'(ws_reg);
    assign err     = WS_W'({tc_reg, 1'b0}) >= ws_reg;
    assign divisor = w - CNT_W'({tc_reg, 1'b0});
    assign hi_idx  = w - CNT_W'(tc_reg) - CNT_W'(1);
    assign wp_inc  = CNT_W'(wp_reg) + CNT_W'(1);
    assign ins_n   = status.full ? (w - CNT_W'(1)) : fill_reg;
    assign acc_sum = acc_reg + SUM_W'(cell_rdata);
    assign trial   = {rem_reg, quot_reg[SUM_W-1]};
    assign trial_ge = trial >= (CNT_W + 1)'(divisor);
    assign restart = cfg_we && ((cfg_index == REG_WINDOW_SIZE) || (cfg_index == REG_TRIM_COUNT));

    assign status.zero_win = (w == '0);
    assign status.full     = (fill_reg == w);
    assign status.mean_ok  = (fill_reg == w) && !err;
    assign status.sum_last = ({1'b0, idx_reg} == hi_idx);
    assign status.div_last = (dcnt_reg == DCNT_W'(SUM_W - 1));

    stm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (cmd.insert),
        .waddr (wp_reg),
        .wdata (sample_reg),
        .raddr (wp_reg),
        .rdata (ring_rdata)
    );

    stm_sorter u_sorter (
        .aclk    (aclk),
        .remove  (cmd.remove),
        .insert  (cmd.insert),
        .n       (cmd.remove ? w : ins_n),
        .v       (cmd.remove ? ring_rdata : sample_reg),
        .rd_idx  (idx_reg),
        .rd_data (cell_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg   <= WS_W'(MAX_WINDOW);
            tc_reg   <= TC_W'(1);
            wp_reg   <= '0;
            fill_reg <= '0;
        end else if (restart) begin
            if (cfg_index == REG_WINDOW_SIZE) begin
                ws_reg <= cfg_data;
            end else begin
                tc_reg <= cfg_data[TC_W-1:0];
            end
            wp_reg   <= '0;
            fill_reg <= '0;
        end else if (cmd.accept && (fill_reg > w)) begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end else if (cmd.insert) begin
            wp_reg <= (wp_inc >= w) ? '0 : wp_inc[IDX_W-1:0];
            if (!status.full) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= s_sample;
        end
        if (cmd.sum_init) begin
            acc_reg <= '0;
            idx_reg <= IDX_W'(tc_reg);
        end else if (cmd.sum_step) begin
            acc_reg <= acc_sum;
            idx_reg <= idx_reg + IDX_W'(1);
            if (status.sum_last) begin
                quot_reg <= acc_sum;
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
        end else if (cmd.div_step) begin
            rem_reg  <= trial_ge ? CNT_W'(trial - (CNT_W + 1)'(divisor)) : trial[CNT_W-1:0];
            quot_reg <= {quot_reg[SUM_W-2:0], trial_ge};
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
        if (cmd.out_load) begin
            out_ready_reg <= status.mean_ok;
            out_err_reg   <= err;
            out_avg_reg   <= status.mean_ok ? quot_reg[SAMPLE_BITS-1:0] : '0;
        end
    end

    assign m_ready_res    = out_ready_reg;
    assign m_config_error = out_err_reg;
    assign m_average      = out_avg_reg;

    // the running remainder never reaches the divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |=> (rem_reg < divisor))
        else $error("divider remainder out of range");

    // an insert never grows the window past its length
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert && !restart |=> (fill_reg <= w))
        else $error("fill count beyond window");

endmodule

[sv/stm_ctrl.sv]
// ----------------------------------------------------------------------------
// stm_ctrl
// Sequencer: read old sample, remove, insert and check; sum the middle cells
// and divide if the mean is valid; the output register then gets the result.
// ----------------------------------------------------------------------------
module stm_ctrl
    import stm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = status.zero_win ? ST_FINISH : ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_REMOVE;
            end
            ST_REMOVE: begin
                cmd.remove = status.full;
                state_next = ST_INSERT;
            end
            ST_INSERT: begin
                cmd.insert = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.mean_ok) begin
                    cmd.sum_init = 1'b1;
                    state_next   = ST_SUM;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (status.sum_last) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    a_accept_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> (state_reg == ST_READ) || (state_reg == ST_FINISH))
        else $error("accepted beat did not start processing");

    a_finish_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) && out_free |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("result not presented after finish");

endmodule
